FILE: rtl/dshot_pkg.sv
// Shared types, codes and constants of the DShot frame transmitter.
// Used by dshot_core and by the dshot_frame_transmitter top level.
package dshot_pkg;

    localparam int FRAME_BITS = 16;
    localparam int LINES_MAX  = 4;
    localparam int CFG_WIDTH  = 16;

    localparam logic [CFG_WIDTH-1:0] BIT_PERIOD_RESET     = 16'd139;
    localparam logic [CFG_WIDTH-1:0] ZERO_HIGH_TIME_RESET = 16'd41;
    localparam logic [CFG_WIDTH-1:0] ONE_HIGH_TIME_RESET  = 16'd83;

    localparam logic [3:0] LAST_BIT = 4'd15;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_FIRE = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_BIT_PERIOD     = 2'd0,
        CFG_ZERO_HIGH_TIME = 2'd1,
        CFG_ONE_HIGH_TIME  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        op_t         operation;
        logic [1:0]  channel;
        logic [10:0] value;
        logic        telemetry;
    } in_item_t;

    typedef struct packed {
        logic [LINES_MAX-1:0] line_levels;
        logic                 busy_res;
        logic                 frame_done;
        logic                 fire_rejected;
    } out_item_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] bit_period;
        logic [CFG_WIDTH-1:0] zero_high_time;
        logic [CFG_WIDTH-1:0] one_high_time;
    } cfg_regs_t;

    // The checksum is the XOR of the three nibbles of value and telemetry bit.
    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [10:0] value,
                                                          input logic telemetry);
        logic [11:0] body;
        logic [3:0]  sum;
        body = {value, telemetry};
        sum  = body[11:8] ^ body[7:4] ^ body[3:0];
        return {body, sum};
    endfunction

endpackage

FILE: rtl/dshot_frame_transmitter.sv
// The block takes one transfer on the input channel in every clock cycle unless the input
// stalls; each transfer yields exactly one result, registered in the result register, or in
// the skid register while the output stalls. All frame state is updated by a single pass of
// logic between the input and the result register. A two-entry output buffer (result register
// plus skid register) keeps the input open while one result waits to be taken; the input
// stalls only when both entries are full. Configuration writes are always taken.
//
// Top level of the DShot frame transmitter; depends on dshot_pkg and dshot_core.
module dshot_frame_transmitter #(
    parameter int CHANNELS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dshot_pkg::in_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dshot_pkg::out_item_t  out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import dshot_pkg::*;

    cfg_regs_t cfg_reg;
    out_item_t result;
    out_item_t out_reg;
    out_item_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      in_fire;
    logic      out_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;

    dshot_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_fire),
        .item   (in_item),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period     <= BIT_PERIOD_RESET;
            cfg_reg.zero_high_time <= ZERO_HIGH_TIME_RESET;
            cfg_reg.one_high_time  <= ONE_HIGH_TIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIT_PERIOD:     cfg_reg.bit_period     <= cfg_data;
                CFG_ZERO_HIGH_TIME: cfg_reg.zero_high_time <= cfg_data;
                CFG_ONE_HIGH_TIME:  cfg_reg.one_high_time  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in front of it");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && in_fire |=> skid_valid_reg)
        else $error("result of a transfer lost while the output stalled");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && skid_valid_reg |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved forward after an output transfer");

endmodule

FILE: rtl/dshot_core.sv
// Frame staging, shifters and bit-cell timing of the DShot transmitter.
// Updates all state for one transfer per cycle while accept is high; depends on dshot_pkg.
module dshot_core #(
    parameter int CHANNELS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  dshot_pkg::in_item_t   item,
    input  dshot_pkg::cfg_regs_t  cfg,
    output dshot_pkg::out_item_t  result
);
    import dshot_pkg::*;

    logic [FRAME_BITS-1:0] staged_reg [CHANNELS];
    logic [FRAME_BITS-1:0] staged_next [CHANNELS];
    logic [FRAME_BITS-1:0] shift_reg [CHANNELS];
    logic [FRAME_BITS-1:0] shift_next [CHANNELS];
    logic [3:0]            bit_index_reg;
    logic [3:0]            bit_index_next;
    logic [CFG_WIDTH-1:0]  cell_count_reg;
    logic [CFG_WIDTH-1:0]  cell_count_next;
    logic                  sending_reg;
    logic                  sending_next;
    logic [CHANNELS-1:0]   levels_reg;
    logic [CHANNELS-1:0]   levels_next;
    logic                  done;
    logic                  rejected;

    always_comb
    begin
        staged_next     = staged_reg;
        shift_next      = shift_reg;
        bit_index_next  = bit_index_reg;
        cell_count_next = cell_count_reg;
        sending_next    = sending_reg;
        levels_next     = levels_reg;
        done            = 1'b0;
        rejected        = 1'b0;
        if (accept)
        begin
            unique case (item.operation)
                OP_TICK:
                begin
                    if (sending_reg)
                    begin
                        if (cell_count_reg >= cfg.bit_period)
                        begin
                            cell_count_next = '0;
                        end
                        else
                        begin
                            cell_count_next = cell_count_reg + 16'd1;
                        end
                        if (cell_count_next == '0)
                        begin
                            levels_next = '1;
                        end
                        if (cell_count_next == cfg.zero_high_time)
                        begin
                            for (int c = 0; c < CHANNELS; c++)
                            begin
                                if (!shift_reg[c][FRAME_BITS-1])
                                begin
                                    levels_next[c] = 1'b0;
                                end
                            end
                        end
                        if (cell_count_next == cfg.one_high_time)
                        begin
                            levels_next = '0;
                            for (int c = 0; c < CHANNELS; c++)
                            begin
                                shift_next[c] = {shift_reg[c][FRAME_BITS-2:0], 1'b0};
                            end
                            if (bit_index_reg == LAST_BIT)
                            begin
                                bit_index_next = '0;
                                sending_next   = 1'b0;
                                done           = 1'b1;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 4'd1;
                            end
                        end
                    end
                end
                OP_LOAD:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (item.channel == 2'(c))
                        begin
                            staged_next[c] = build_frame(item.value, item.telemetry);
                        end
                    end
                end
                OP_FIRE:
                begin
                    if (sending_reg)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        shift_next      = staged_reg;
                        bit_index_next  = '0;
                        cell_count_next = cfg.bit_period;
                        sending_next    = 1'b1;
                    end
                end
                OP_NOP:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        result.line_levels = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            result.line_levels[c] = levels_next[c];
        end
        result.busy_res      = sending_next;
        result.frame_done    = done;
        result.fire_rejected = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                staged_reg[c] <= '0;
                shift_reg[c]  <= '0;
            end
            bit_index_reg  <= '0;
            cell_count_reg <= '0;
            sending_reg    <= 1'b0;
            levels_reg     <= '0;
        end
        else
        begin
            staged_reg     <= staged_next;
            shift_reg      <= shift_next;
            bit_index_reg  <= bit_index_next;
            cell_count_reg <= cell_count_next;
            sending_reg    <= sending_next;
            levels_reg     <= levels_next;
        end
    end

    a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done |=> !sending_reg && bit_index_reg == '0)
        else $error("frame end left the transmitter busy");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rejected |-> sending_reg)
        else $error("fire rejected while idle");

    a_index_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg != '0 |-> sending_reg)
        else $error("bit index advanced without a frame in progress");

    a_idle_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> levels_reg == '0)
        else $error("lines high while idle");

endmodule
